### rtl/quaternion_to_euler_angles_defines.svh
// assertion macros for the quaternion to euler angle converter
// used by quaternion_to_euler_angles.sv, no other dependencies
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define Q2E_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q2e check failed");

// antecedent implies consequent in the cycle after
`define Q2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q2e check failed");

`endif

### rtl/q2e_pkg.sv
// shared types, widths and constants of the quaternion to euler converter
// no dependencies
`default_nettype none

package q2e_pkg;

    localparam int W_ARG = 36;
    localparam int W_CX  = 54;
    localparam int W_Z   = 28;
    localparam int SQRT_STEPS = 29;

    localparam logic signed [15:0] ANGLE_PI      = 16'sd25736;
    localparam logic signed [15:0] ANGLE_HALF_PI = 16'sd12868;

    typedef enum logic [1:0] {
        LOCK_NONE = 2'd0,
        LOCK_POS  = 2'd1,
        LOCK_NEG  = 2'd2
    } t_lock_kind;

    typedef struct packed {
        logic signed [W_ARG-1:0] s;
        logic signed [W_ARG-1:0] sr;
        logic signed [W_ARG-1:0] cr;
        logic signed [W_ARG-1:0] ya;
        logic signed [W_ARG-1:0] yx;
        t_lock_kind              kind;
    } t_pay;

    // atan(2^-i) in units of 2^-24 rad
    function automatic logic signed [W_Z-1:0] atan_entry(input logic [4:0] i);
        logic signed [W_Z-1:0] v;
        case (i)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/q2e_cordic.sv
// pipelined vectoring cordic, atan2(y, x) in q3.13 clamped to +/-pi
// depends on q2e_pkg
`default_nettype none

module q2e_cordic import q2e_pkg::*; #(
    parameter int ITERATIONS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [W_ARG-1:0] i_y,
    input  logic signed [W_ARG-1:0] i_x,
    output logic signed [15:0]      o_angle
);

    logic signed [W_CX-1:0] r_cx   [0:ITERATIONS];
    logic signed [W_CX-1:0] r_cy   [0:ITERATIONS];
    logic signed [W_Z-1:0]  r_z    [0:ITERATIONS];
    logic                   r_zero [0:ITERATIONS];
    logic signed [15:0]     r_angle;

    logic signed [W_CX-1:0] xs, ys, n_cx, n_cy;
    logic signed [W_Z-1:0]  n_z;
    logic signed [W_Z-1:0]  zr;
    logic signed [15:0]     n_angle;

    // quadrant pre-rotation
    always_comb begin
        xs = W_CX'(i_x) <<< 16;
        ys = W_CX'(i_y) <<< 16;
        n_cx = xs;
        n_cy = ys;
        n_z  = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                n_cx = ys;
                n_cy = -xs;
                n_z  = atan_entry(5'd0) <<< 1;
            end else begin
                n_cx = -ys;
                n_cy = xs;
                n_z  = -(atan_entry(5'd0) <<< 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]   <= n_cx;
            r_cy[0]   <= n_cy;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (r_cy[g] > 0) begin
                    r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                    r_z[g+1]  <= r_z[g] + atan_entry(5'(g));
                end else begin
                    r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                    r_z[g+1]  <= r_z[g] - atan_entry(5'(g));
                end
            end
        end
    end

    // round half up to q3.13 and clamp
    always_comb begin
        zr = (r_z[ITERATIONS] + W_Z'(1024)) >>> 11;
        if (r_zero[ITERATIONS]) begin
            n_angle = '0;
        end else if (zr > W_Z'(ANGLE_PI)) begin
            n_angle = ANGLE_PI;
        end else if (zr < -W_Z'(ANGLE_PI)) begin
            n_angle = -ANGLE_PI;
        end else begin
            n_angle = zr[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

### rtl/quaternion_to_euler_angles.sv
// quaternion to zyx euler angles, top level with product, sqrt and cordic stages
// depends on q2e_pkg, q2e_cordic and quaternion_to_euler_angles_defines.svh
//
// channel   dir  fields (lowest bit first)
// s_axis    in   tdata: quat_w, quat_x, quat_y, quat_z (16 bits each)
// m_axis    out  tdata: roll_angle 16, pitch_angle 15, yaw_angle 17; tuser: lock_kind
// cfg       in   wr_data: gimbal_margin
//
// one beat per cycle unless stalled; the pipeline includes the
// 29-step square root chain and the cordic iteration stages
// the whole pipeline advances unless a finished beat waits at the output
// reset clears valid bits and sets the margin to 3
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles import q2e_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic [1:0]  o_m_axis_tuser,   // lock_kind
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int LAT = 37 + CORDIC_ITERATIONS;
    localparam int CLAT = CORDIC_ITERATIONS + 2;

    logic        r_v [0:LAT-1];
    logic [15:0] r_margin;
    logic        en;

    assign en = !r_v[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= 16'd3;
        end else if (i_cfg_wr_en) begin
            r_margin <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    // stage a: products
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] r_wy, r_zx, r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz;
    logic signed [15:0] r_a_w, r_a_x;

    assign qw = i_s_axis_tdata[15:0];
    assign qx = i_s_axis_tdata[31:16];
    assign qy = i_s_axis_tdata[47:32];
    assign qz = i_s_axis_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wy <= qw * qy;
            r_zx <= qz * qx;
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
            r_a_w <= qw;
            r_a_x <= qx;
        end
    end

    // stage b: sums
    localparam logic signed [W_ARG-1:0] UNIT = W_ARG'(1) <<< 28;
    logic signed [W_ARG-1:0] r_b_s, r_b_sr, r_b_cr, r_b_sy, r_b_cy;
    logic signed [15:0]      r_b_w, r_b_x;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_s  <= (W_ARG'(r_wy) - W_ARG'(r_zx)) <<< 1;
            r_b_sr <= (W_ARG'(r_wx) + W_ARG'(r_yz)) <<< 1;
            r_b_cr <= UNIT - ((W_ARG'(r_xx) + W_ARG'(r_yy)) <<< 1);
            r_b_sy <= (W_ARG'(r_wz) + W_ARG'(r_xy)) <<< 1;
            r_b_cy <= UNIT - ((W_ARG'(r_yy) + W_ARG'(r_zz)) <<< 1);
            r_b_w  <= r_a_w;
            r_b_x  <= r_a_x;
        end
    end

    // stage c: lock test
    logic signed [W_ARG-1:0] thr, s_abs;
    logic                    lock_pos, lock_neg;
    t_pay                    n_c_pay, r_c_pay, r_d_pay;
    logic [27:0]             r_c_mag;
    logic [55:0]             r_d_sq;

    always_comb begin
        thr = UNIT - W_ARG'(r_margin);
        lock_pos = r_b_s >= thr;
        lock_neg = r_b_s <= -thr;
        s_abs = (r_b_s < 0) ? -r_b_s : r_b_s;
        n_c_pay.s  = r_b_s;
        n_c_pay.sr = r_b_sr;
        n_c_pay.cr = r_b_cr;
        if (lock_pos || lock_neg) begin
            n_c_pay.ya = W_ARG'(r_b_x);
            n_c_pay.yx = W_ARG'(r_b_w);
        end else begin
            n_c_pay.ya = r_b_sy;
            n_c_pay.yx = r_b_cy;
        end
        n_c_pay.kind = lock_pos ? LOCK_POS : (lock_neg ? LOCK_NEG : LOCK_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_pay <= n_c_pay;
            r_c_mag <= s_abs[27:0];
            r_d_pay <= r_c_pay;
            r_d_sq  <= r_c_mag * r_c_mag;
        end
    end

    // stage e and square root steps
    logic [57:0] r_rem [0:SQRT_STEPS];
    logic [57:0] r_res [0:SQRT_STEPS];
    t_pay        r_pay [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= (58'd1 << 56) - 58'(r_d_sq);
            r_res[0] <= '0;
            r_pay[0] <= r_d_pay;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [57:0] BITK = 58'd1 << (56 - 2 * k);
        logic [57:0] trial;
        assign trial = r_res[k] + BITK;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pay[k+1] <= r_pay[k];
                if (r_rem[k] >= trial) begin
                    r_rem[k+1] <= r_rem[k] - trial;
                    r_res[k+1] <= (r_res[k] >> 1) + BITK;
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
            end
        end
    end

    // cordics
    logic signed [15:0] pitch_a, roll_a, yaw_a;
    t_lock_kind         r_kd [0:CLAT-1];

    q2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_pitch (
        .i_clk(i_clk), .i_en(en),
        .i_y(r_pay[SQRT_STEPS].s),
        .i_x(W_ARG'(r_res[SQRT_STEPS][28:0])),
        .o_angle(pitch_a)
    );

    q2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_roll (
        .i_clk(i_clk), .i_en(en),
        .i_y(r_pay[SQRT_STEPS].sr),
        .i_x(r_pay[SQRT_STEPS].cr),
        .o_angle(roll_a)
    );

    q2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_yaw (
        .i_clk(i_clk), .i_en(en),
        .i_y(r_pay[SQRT_STEPS].ya),
        .i_x(r_pay[SQRT_STEPS].yx),
        .o_angle(yaw_a)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kd[0] <= r_pay[SQRT_STEPS].kind;
            for (int k = 1; k < CLAT; k++) r_kd[k] <= r_kd[k-1];
        end
    end

    // output stage
    logic signed [15:0] n_roll, r_roll;
    logic signed [14:0] n_pitch, r_pitch;
    logic signed [16:0] n_yaw, r_yaw;
    t_lock_kind         r_kind;

    always_comb begin
        unique case (r_kd[CLAT-1])
            LOCK_POS: begin
                n_roll  = '0;
                n_pitch = ANGLE_HALF_PI[14:0];
                n_yaw   = -(17'(yaw_a) <<< 1);
            end
            LOCK_NEG: begin
                n_roll  = '0;
                n_pitch = -ANGLE_HALF_PI[14:0];
                n_yaw   = 17'(yaw_a) <<< 1;
            end
            default: begin
                n_roll = roll_a;
                if (pitch_a > ANGLE_HALF_PI) begin
                    n_pitch = ANGLE_HALF_PI[14:0];
                end else if (pitch_a < -ANGLE_HALF_PI) begin
                    n_pitch = -ANGLE_HALF_PI[14:0];
                end else begin
                    n_pitch = pitch_a[14:0];
                end
                n_yaw = 17'(yaw_a);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
            r_kind  <= r_kd[CLAT-1];
        end
    end

    assign o_m_axis_tvalid = r_v[LAT-1];
    assign o_m_axis_tdata  = {r_yaw, r_pitch, r_roll};
    assign o_m_axis_tuser  = r_kind;

    `Q2E_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    `Q2E_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_v[0])
    `Q2E_ASSERT_IMPL(a_lock_roll_zero, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != LOCK_NONE), o_m_axis_tdata[15:0] == 16'd0)
    `Q2E_ASSERT_IMPL(a_pos_lock_pitch, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == LOCK_POS), o_m_axis_tdata[30:16] == ANGLE_HALF_PI[14:0])

endmodule

`default_nettype wire

### test/q2e_checker.sv
// predicts roll, pitch, yaw and lock kind for each accepted quaternion beat and
// compares them with the output beats; depends on q2e_pkg
module q2e_checker import q2e_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic [1:0]  i_out_user,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [16:0] yaw;
        t_lock_kind  kind;
    } t_angles;

    t_angles     angles_due[$];
    logic [15:0] margin;

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bit_pos;
        res = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > v) bit_pos >>= 2;
        while (bit_pos != 0) begin
            if (v >= res + bit_pos) begin
                v -= res + bit_pos;
                res = (res >> 1) + bit_pos;
            end else begin
                res >>= 1;
            end
            bit_pos >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_step(int i);
        longint tbl [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        return tbl[i];
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint cx, cy, ang, t, dx, dy, r;
        int n;
        if (x == 0 && y == 0) return 0;
        n = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
        cx = x * 65536;
        cy = y * 65536;
        ang = 0;
        if (cx < 0) begin
            t = cx;
            if (cy >= 0) begin
                cx = cy; cy = -t; ang = atan_step(0) * 2;
            end else begin
                cx = -cy; cy = t; ang = -atan_step(0) * 2;
            end
        end
        for (int i = 0; i < n; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cy > 0) begin
                cx += dx; cy -= dy; ang += atan_step(i);
            end else begin
                cx -= dx; cy += dy; ang -= atan_step(i);
            end
        end
        r = floor_shift(ang + 1024, 11);
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        return r;
    endfunction

    function automatic t_angles convert_quat(logic [63:0] d, logic [15:0] mg);
        t_angles a;
        longint w, x, y, z, s, thr, roll, pitch, yaw, c;
        longint unsigned mag;
        w = longint'($signed(d[15:0]));
        x = longint'($signed(d[31:16]));
        y = longint'($signed(d[47:32]));
        z = longint'($signed(d[63:48]));
        s = 2 * (w * y - z * x);
        thr = 64'sd268435456 - longint'(mg);
        if (s >= thr) begin
            pitch = 12868; roll = 0; yaw = -2 * vector_angle(x, w); a.kind = LOCK_POS;
        end else if (s <= -thr) begin
            pitch = -12868; roll = 0; yaw = 2 * vector_angle(x, w); a.kind = LOCK_NEG;
        end else begin
            mag = longint'(s < 0 ? -s : s);
            c = int_sqrt((64'd1 << 56) - mag * mag);
            pitch = vector_angle(s, c);
            if (pitch > 12868) pitch = 12868;
            if (pitch < -12868) pitch = -12868;
            roll = vector_angle(2 * (w * x + y * z), 268435456 - 2 * (x * x + y * y));
            yaw = vector_angle(2 * (w * z + x * y), 268435456 - 2 * (y * y + z * z));
            a.kind = LOCK_NONE;
        end
        a.roll = roll[15:0];
        a.pitch = pitch[14:0];
        a.yaw = yaw[16:0];
        return a;
    endfunction

    assign o_pending = angles_due.size();

    always @(posedge i_clk) begin
        t_angles e;
        if (!i_rst_n) begin
            margin <= 16'd3;
            angles_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) angles_due.push_back(convert_quat(i_in_data, margin));
            if (i_cfg_wr_en) margin <= i_cfg_wr_data;
            if (i_out_valid && i_out_ready) begin
                if (angles_due.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected output beat %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = angles_due.pop_front();
                    if (i_out_data[15:0] !== e.roll || i_out_data[30:16] !== e.pitch ||
                        i_out_data[47:31] !== e.yaw || i_out_user !== e.kind) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp r%h p%h y%h k%0d got r%h p%h y%h k%0d",
                                e.roll, e.pitch, e.yaw, e.kind, i_out_data[15:0],
                                i_out_data[30:16], i_out_data[47:31], i_out_user);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### test/testbench.sv
// stimulus and verdict for the quaternion to euler converter
// depends on quaternion_to_euler_angles, q2e_checker and q2e_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 37 + 16;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [47:0] m_data;
    logic [1:0]  m_user;
    logic        cfg_en = 0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_stall = 0;
    bit          hold_off = 0;
    longint      cycles = 0;

    always #10 i_clk = ~i_clk;

    quaternion_to_euler_angles dut (
        .i_clk, .i_rst_n,
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_wr_en(cfg_en), .i_cfg_wr_data(cfg_data)
    );

    q2e_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready),
        .i_out_data(m_data), .i_out_user(m_user),
        .i_cfg_wr_en(cfg_en), .i_cfg_wr_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [63:0] unit_quat();
        real a, b, c, d, n;
        a = $itor($signed($urandom_range(2000))) - 1000;
        b = $itor($signed($urandom_range(2000))) - 1000;
        c = $itor($signed($urandom_range(2000))) - 1000;
        d = $itor($signed($urandom_range(2000))) - 1000;
        if ($urandom_range(3) == 0) begin
            // near gimbal lock: y equals w and z equals minus x, or y equals minus w and z equals x
            c = a; d = -b;
            if ($urandom_range(1)) begin c = -a; d = b; end
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0) return {48'd0, 16'h4000};
        return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
                16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
    endfunction

    task automatic send_beat(logic [63:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge i_clk);
        end
        s_valid <= 1;
        s_data <= d;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_margin(logic [15:0] v);
        drain();
        cfg_en <= 1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_en <= 0;
    endtask

    initial begin
        logic [15:0] margins [5] = '{16'd0, 16'd65535, 16'd3, 16'd1000, 16'd20000};
        logic [63:0] directed [$] = '{
            {16'd0, 16'd0, 16'd0, 16'h4000}, {16'd0, 16'd0, 16'd0, 16'hC000},
            {16'd0, 16'd0, 16'd0, 16'd0}, {16'h4000, 16'h4000, 16'h4000, 16'h4000},
            {16'hC000, 16'hC000, 16'hC000, 16'hC000}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
            {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, {16'd0, 16'h2D41, 16'd0, 16'h2D41},
            {16'hD2BF, 16'd0, 16'h2D41, 16'd0}, {16'h2D41, 16'd0, 16'hD2BF, 16'd0},
            {16'd0, 16'h2D41, 16'd0, 16'hD2BF}, {16'd0, 16'd0, 16'h4000, 16'd0},
            {16'd0, 16'd0, 16'd0, 16'hC001}, {16'd0, 16'd0, 16'h4000, 16'hC000},
            {16'd0, 16'h4000, 16'd0, 16'd0}, {16'h4000, 16'd0, 16'd0, 16'd0},
            {16'd0, 16'hC000, 16'd0, 16'd0}, {16'd0, 16'h2000, 16'h2000, 16'h2000}};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (directed[i]) send_beat(directed[i]);
        for (int ph = 0; ph < 5; ph++) begin
            set_margin(margins[ph]);
            send_idle = (ph == 1 || ph == 4) ? 71 : (ph == 3 ? 38 : 0);
            recv_stall = (ph == 2 || ph == 4) ? 71 : (ph == 3 ? 38 : 0);
            if (ph == 0) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 240; k++) begin
                if ($urandom_range(9) < 7) send_beat(unit_quat());
                else send_beat({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
                if (k == 120) begin
                    s_valid <= 0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end
        recv_stall = 0;
        drain();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler_angles.sv
test/q2e_checker.sv
test/testbench.sv
